// ----- hw/rtl/arc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants of the adaptive replacement cache unit.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;
    localparam int CAP_W           = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam int CNT_W           = 32;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;
    localparam logic [0:0] REG_CAP = 1'b0;

    typedef enum logic [1:0] {
        L_T1,
        L_T2,
        L_B1,
        L_B2
    } t_lst;

    typedef enum logic [1:0] {
        GH_NONE,
        GH_B1,
        GH_B2
    } t_ghost;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_SCAN_START,
        OP_SCAN,
        OP_FLUSH,
        OP_DECIDE,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_P_UPD,
        OP_SEL_FOUND,
        OP_SEL_REPL,
        OP_SEL_LRU,
        OP_UNLINK,
        OP_APPEND,
        OP_APPEND_GHOST,
        OP_DROP,
        OP_DROP_EV,
        OP_INSERT,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        t_lst lst;
    } t_cmd;

    typedef struct packed {
        logic found;
        t_lst found_list;
        logic cnt_last;
        logic div_last;
        logic case_a;
        logic a_lt;
        logic sum_ge;
        logic sum_2c;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/arc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_dp
// Datapath: directory memories, list pointers, target divider, counters and
// the result register.
// ----------------------------------------------------------------------------
module arc_dp #(
    parameter int MAX_ENTRIES = arc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = arc_pkg::KEY_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  arc_pkg::t_cmd             i_cmd,
    input  logic                      i_cfg_wr,
    input  logic [arc_pkg::CAP_W-1:0] i_cap,
    input  logic [KEY_BITS-1:0]       i_access_key,
    input  logic                      i_out_ready,
    output arc_pkg::t_stat            o_stat,
    output logic                      o_out_valid,
    output logic                      o_hit,
    output logic [1:0]                o_ghost_hit,
    output logic                      o_evict_valid,
    output logic [KEY_BITS-1:0]       o_evict_key,
    output logic [arc_pkg::CAP_W-1:0] o_target_after,
    output logic [arc_pkg::CNT_W-1:0] o_hit_count,
    output logic [arc_pkg::CNT_W-1:0] o_miss_count
);
    import arc_pkg::*;

    localparam int NSLOT = 2 * MAX_ENTRIES;
    localparam int SW    = $clog2(NSLOT);
    localparam int LW    = $clog2(NSLOT + 1);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int DW    = $clog2(LW + 1);

    // directory
    logic                m_valid [NSLOT];
    logic [KEY_BITS-1:0] m_key   [NSLOT];
    logic [1:0]          m_list  [NSLOT];
    logic [SW-1:0]       m_prev  [NSLOT];
    logic [SW-1:0]       m_next  [NSLOT];

    logic                r_rd_valid;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [1:0]          r_rd_list;
    logic [SW-1:0]       r_rd_prev;
    logic [SW-1:0]       r_rd_next;

    logic [SW-1:0] r_head [4];
    logic [SW-1:0] r_tail [4];
    logic [LW-1:0] r_len  [4];
    logic [SW-1:0] n_head [4];
    logic [SW-1:0] n_tail [4];
    logic [LW-1:0] n_len  [4];

    logic [SW-1:0]       r_cnt;
    logic                r_scan_v;
    logic [SW-1:0]       r_scan_idx;
    logic [KEY_BITS-1:0] r_key;
    logic                r_found_ok;
    logic [SW-1:0]       r_found_idx;
    t_lst                r_found_list;
    logic                r_free_ok;
    logic [SW-1:0]       r_free_idx;
    logic                r_freed_ok;
    logic [SW-1:0]       r_freed_idx;
    logic [SW-1:0]       r_slot;
    logic                r_ok;
    t_lst                r_src;
    logic                r_hit;
    t_ghost              r_ghost;
    logic                r_ev;
    logic [KEY_BITS-1:0] r_evk;
    logic [CW-1:0]       r_p;
    logic [CNT_W-1:0]    r_hits;
    logic [CNT_W-1:0]    r_misses;
    logic [LW-1:0]       r_rem;
    logic [LW-1:0]       r_quo;
    logic [LW-1:0]       r_dvs;
    logic [DW-1:0]       r_dcnt;

    logic [CW-1:0]   c_eff;
    logic [SW-1:0]   rd_addr;
    t_lst            ls;
    t_lst            repl_src;
    logic [SW-1:0]   sel_head;
    logic [SW-1:0]   sel_tail;
    logic [LW-1:0]   sel_len;
    logic            ins_ok;
    logic [SW-1:0]   ins_idx;
    logic            in_b2;
    logic [LW:0]     div_tmp;
    logic [LW-1:0]   p_step;
    logic [LW:0]     p_sum;
    logic [LW:0]     c_x;
    logic [LW+1:0]   len_sum;

    logic            v_we, k_we, l_we, p_we, x_we;
    logic [SW-1:0]   v_addr, k_addr, l_addr, p_addr, x_addr;
    logic            v_d;
    logic [1:0]      l_d;
    logic [SW-1:0]   p_d, x_d;
    logic            ap_en;
    logic [SW-1:0]   ap_slot;

    always_comb begin
        if (i_cap == '0) begin
            c_eff = CW'(1);
        end else if (int'(i_cap) > MAX_ENTRIES) begin
            c_eff = CW'(MAX_ENTRIES);
        end else begin
            c_eff = CW'(i_cap);
        end
    end

    assign c_x     = (LW+1)'(c_eff);
    assign len_sum = (LW+2)'(r_len[L_T1]) + (LW+2)'(r_len[L_T2])
                   + (LW+2)'(r_len[L_B1]) + (LW+2)'(r_len[L_B2]);

    assign rd_addr = (i_cmd.op == OP_SCAN) ? r_cnt : r_slot;
    assign in_b2   = (r_ghost == GH_B2);

    // victim list choice for replacement, with fallback to the other resident list
    always_comb begin
        logic [LW:0] t1n;
        logic [LW:0] px;
        t1n = (LW+1)'(r_len[L_T1]);
        px  = (LW+1)'(r_p);
        if (t1n != '0 && (px < t1n || (t1n == px && in_b2))) begin
            repl_src = L_T1;
        end else if (r_len[L_T2] == '0) begin
            repl_src = L_T1;
        end else begin
            repl_src = L_T2;
        end
    end

    always_comb begin
        case (i_cmd.op)
            OP_UNLINK:              ls = t_lst'(r_rd_list);
            OP_APPEND, OP_SEL_LRU:  ls = i_cmd.lst;
            OP_APPEND_GHOST:        ls = (r_src == L_T1) ? L_B1 : L_B2;
            OP_SEL_REPL:            ls = repl_src;
            default:                ls = L_T1;
        endcase
    end

    assign sel_head = r_head[ls];
    assign sel_tail = r_tail[ls];
    assign sel_len  = r_len[ls];

    assign ins_ok  = r_free_ok | r_freed_ok;
    assign ins_idx = (r_free_ok && (!r_freed_ok || r_free_idx < r_freed_idx))
                   ? r_free_idx : r_freed_idx;

    // list relinking and directory writes
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_len   = r_len;
        v_we    = 1'b0;  v_addr = r_slot;  v_d = 1'b0;
        k_we    = 1'b0;  k_addr = ins_idx;
        l_we    = 1'b0;  l_addr = r_slot;  l_d = 2'(ls);
        p_we    = 1'b0;  p_addr = r_slot;  p_d = sel_tail;
        x_we    = 1'b0;  x_addr = sel_tail; x_d = r_slot;
        ap_en   = 1'b0;
        ap_slot = r_slot;
        case (i_cmd.op)
            OP_CLR: begin
                v_we   = 1'b1;
                v_addr = r_cnt;
            end
            OP_DROP, OP_DROP_EV: begin
                v_we = r_ok;
            end
            OP_INSERT: begin
                v_we    = ins_ok;
                v_addr  = ins_idx;
                v_d     = 1'b1;
                k_we    = ins_ok;
                ap_en   = ins_ok;
                ap_slot = ins_idx;
            end
            OP_APPEND: begin
                ap_en = 1'b1;
            end
            OP_APPEND_GHOST: begin
                ap_en = r_ok;
            end
            OP_UNLINK: begin
                if (r_ok && sel_len != '0) begin
                    if (sel_len == LW'(1)) begin
                        n_head[ls] = '0;
                        n_tail[ls] = '0;
                    end else if (r_slot == sel_head) begin
                        n_head[ls] = r_rd_next;
                    end else if (r_slot == sel_tail) begin
                        n_tail[ls] = r_rd_prev;
                    end else begin
                        x_we   = 1'b1;
                        x_addr = r_rd_prev;
                        x_d    = r_rd_next;
                        p_we   = 1'b1;
                        p_addr = r_rd_next;
                        p_d    = r_rd_prev;
                    end
                    n_len[ls] = sel_len - LW'(1);
                end
            end
            default: ;
        endcase
        if (ap_en) begin
            l_we   = 1'b1;
            l_addr = ap_slot;
            if (sel_len == '0) begin
                n_head[ls] = ap_slot;
            end else begin
                x_we   = 1'b1;
                x_addr = sel_tail;
                x_d    = ap_slot;
                p_we   = 1'b1;
                p_addr = ap_slot;
                p_d    = sel_tail;
            end
            n_tail[ls] = ap_slot;
            n_len[ls]  = sel_len + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_we) m_valid[v_addr] <= v_d;
        if (k_we) m_key[k_addr]   <= r_key;
        if (l_we) m_list[l_addr]  <= l_d;
        if (p_we) m_prev[p_addr]  <= p_d;
        if (x_we) m_next[x_addr]  <= x_d;
        r_rd_valid <= m_valid[rd_addr];
        r_rd_key   <= m_key[rd_addr];
        r_rd_list  <= m_list[rd_addr];
        r_rd_prev  <= m_prev[rd_addr];
        r_rd_next  <= m_next[rd_addr];
    end

    assign div_tmp = {r_rem, r_quo[LW-1]};
    assign p_step  = (r_dvs == '0 || r_quo == '0) ? LW'(1) : r_quo;
    assign p_sum   = (LW+1)'(r_p) + (LW+1)'(p_step);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_scan_v    <= 1'b0;
            r_head      <= '{default: '0};
            r_tail      <= '{default: '0};
            r_len       <= '{default: '0};
            r_p         <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_scan_v <= (i_cmd.op == OP_SCAN);
            if (i_cmd.op == OP_DONE) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_wr) begin
                r_cnt  <= '0;
                r_head <= '{default: '0};
                r_tail <= '{default: '0};
                r_len  <= '{default: '0};
                r_p    <= '0;
            end else begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_len  <= n_len;
                case (i_cmd.op)
                    OP_CLR, OP_SCAN: r_cnt <= r_cnt + SW'(1);
                    OP_SCAN_START:   r_cnt <= '0;
                    OP_DECIDE: begin
                        if (r_found_ok && (r_found_list == L_T1 || r_found_list == L_T2)) begin
                            r_hits <= r_hits + CNT_W'(1);
                        end else begin
                            r_misses <= r_misses + CNT_W'(1);
                        end
                    end
                    OP_P_UPD: begin
                        if (r_ghost == GH_B1) begin
                            r_p <= (p_sum > c_x) ? c_eff : CW'(p_sum);
                        end else if ((LW+1)'(r_p) > (LW+1)'(p_step)) begin
                            r_p <= CW'((LW+1)'(r_p) - (LW+1)'(p_step));
                        end else begin
                            r_p <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        r_scan_idx <= r_cnt;
        if (r_scan_v) begin
            if (!r_found_ok && r_rd_valid && r_rd_key == r_key) begin
                r_found_ok   <= 1'b1;
                r_found_idx  <= r_scan_idx;
                r_found_list <= t_lst'(r_rd_list);
            end
            if (!r_free_ok && !r_rd_valid) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_scan_idx;
            end
        end
        case (i_cmd.op)
            OP_SCAN_START: begin
                r_key      <= i_access_key;
                r_found_ok <= 1'b0;
                r_free_ok  <= 1'b0;
                r_freed_ok <= 1'b0;
                r_ev       <= 1'b0;
                r_evk      <= '0;
            end
            OP_DECIDE: begin
                r_hit <= r_found_ok && (r_found_list == L_T1 || r_found_list == L_T2);
                if (r_found_ok && r_found_list == L_B1) begin
                    r_ghost <= GH_B1;
                end else if (r_found_ok && r_found_list == L_B2) begin
                    r_ghost <= GH_B2;
                end else begin
                    r_ghost <= GH_NONE;
                end
            end
            OP_DIV_LOAD: begin
                r_rem  <= '0;
                r_quo  <= (r_ghost == GH_B1) ? r_len[L_B2] : r_len[L_B1];
                r_dvs  <= (r_ghost == GH_B1) ? r_len[L_B1] : r_len[L_B2];
                r_dcnt <= DW'(LW);
            end
            OP_DIV_STEP: begin
                if (div_tmp >= (LW+1)'(r_dvs)) begin
                    r_rem <= LW'(div_tmp - (LW+1)'(r_dvs));
                    r_quo <= {r_quo[LW-2:0], 1'b1};
                end else begin
                    r_rem <= div_tmp[LW-1:0];
                    r_quo <= {r_quo[LW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - DW'(1);
            end
            OP_SEL_FOUND: begin
                r_slot <= r_found_idx;
                r_ok   <= 1'b1;
            end
            OP_SEL_REPL, OP_SEL_LRU: begin
                r_src  <= ls;
                r_slot <= sel_head;
                r_ok   <= (sel_len != '0);
            end
            OP_APPEND_GHOST: begin
                if (r_ok) begin
                    r_ev  <= 1'b1;
                    r_evk <= r_rd_key;
                end
            end
            OP_DROP, OP_DROP_EV: begin
                if (r_ok) begin
                    r_freed_ok  <= 1'b1;
                    r_freed_idx <= r_slot;
                    if (i_cmd.op == OP_DROP_EV) begin
                        r_ev  <= 1'b1;
                        r_evk <= r_rd_key;
                    end
                end
            end
            OP_DONE: begin
                o_hit          <= r_hit;
                o_ghost_hit    <= 2'(r_ghost);
                o_evict_valid  <= r_ev;
                o_evict_key    <= r_ev ? r_evk : '0;
                o_target_after <= CAP_W'(r_p);
                o_hit_count    <= r_hits;
                o_miss_count   <= r_misses;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.found      = r_found_ok;
        o_stat.found_list = r_found_list;
        o_stat.cnt_last   = (r_cnt == SW'(NSLOT - 1));
        o_stat.div_last   = (r_dcnt == DW'(1));
        o_stat.case_a     = ((LW+1)'(r_len[L_T1]) + (LW+1)'(r_len[L_B1]) == c_x);
        o_stat.a_lt       = ((LW+1)'(r_len[L_T1]) < c_x);
        o_stat.sum_ge     = (len_sum >= (LW+2)'(c_eff));
        o_stat.sum_2c     = (len_sum == {(LW+1)'(c_eff), 1'b0});
        o_stat.out_free   = !o_out_valid || i_out_ready;
    end

endmodule

// ----- hw/rtl/arc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_ctrl
// Sequencer: steps the datapath through search, replacement and relinking.
// ----------------------------------------------------------------------------
module arc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr,
    input  logic           i_in_valid,
    input  arc_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output arc_pkg::t_cmd  o_cmd
);
    import arc_pkg::*;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DECIDE,
        S_DIV_LOAD,
        S_DIV,
        S_P_UPD,
        S_SEL_REPL,
        S_SEL_FOUND,
        S_SEL_LRU,
        S_RD,
        S_UNLINK,
        S_APPEND,
        S_DROP,
        S_INSERT
    } t_state;

    typedef enum logic [1:0] {
        PH_FOUND,
        PH_REPL,
        PH_DROP,
        PH_DROPEV
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    t_lst   r_lru;
    logic   r_gpath;
    logic   r_done;

    assign o_in_ready = (r_state == S_IDLE) && !r_done;

    always_comb begin
        o_cmd.lst = r_lru;
        case (r_state)
            S_CLR:       o_cmd.op = OP_CLR;
            S_IDLE:      o_cmd.op = r_done ? (i_stat.out_free ? OP_DONE : OP_NONE)
                                           : (i_in_valid ? OP_SCAN_START : OP_NONE);
            S_SCAN:      o_cmd.op = OP_SCAN;
            S_FLUSH:     o_cmd.op = OP_FLUSH;
            S_DECIDE:    o_cmd.op = OP_DECIDE;
            S_DIV_LOAD:  o_cmd.op = OP_DIV_LOAD;
            S_DIV:       o_cmd.op = OP_DIV_STEP;
            S_P_UPD:     o_cmd.op = OP_P_UPD;
            S_SEL_REPL:  o_cmd.op = OP_SEL_REPL;
            S_SEL_FOUND: o_cmd.op = OP_SEL_FOUND;
            S_SEL_LRU:   o_cmd.op = OP_SEL_LRU;
            S_UNLINK:    o_cmd.op = OP_UNLINK;
            S_APPEND: begin
                o_cmd.op = (r_phase == PH_REPL) ? OP_APPEND_GHOST : OP_APPEND;
                o_cmd.lst = L_T2;
            end
            S_DROP:      o_cmd.op = (r_phase == PH_DROPEV) ? OP_DROP_EV : OP_DROP;
            S_INSERT:    o_cmd.op = OP_INSERT;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_phase <= PH_FOUND;
            r_lru   <= L_T1;
            r_gpath <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_cfg_wr) begin
            r_state <= S_CLR;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (i_stat.cnt_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    // a finished word waits here until the output register frees up
                    if (r_done) begin
                        if (i_stat.out_free) r_done <= 1'b0;
                    end else if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_stat.cnt_last) r_state <= S_FLUSH;
                end
                S_FLUSH: r_state <= S_DECIDE;
                S_DECIDE: begin
                    r_gpath <= 1'b0;
                    if (i_stat.found &&
                        (i_stat.found_list == L_T1 || i_stat.found_list == L_T2)) begin
                        r_phase <= PH_FOUND;
                        r_state <= S_SEL_FOUND;
                    end else if (i_stat.found) begin
                        r_gpath <= 1'b1;
                        r_state <= S_DIV_LOAD;
                    end else if (i_stat.case_a) begin
                        r_lru   <= i_stat.a_lt ? L_B1 : L_T1;
                        r_phase <= i_stat.a_lt ? PH_DROP : PH_DROPEV;
                        r_state <= S_SEL_LRU;
                    end else if (i_stat.sum_ge && i_stat.sum_2c) begin
                        r_lru   <= L_B2;
                        r_phase <= PH_DROP;
                        r_state <= S_SEL_LRU;
                    end else if (i_stat.sum_ge) begin
                        r_phase <= PH_REPL;
                        r_state <= S_SEL_REPL;
                    end else begin
                        r_state <= S_INSERT;
                    end
                end
                S_DIV_LOAD: r_state <= S_DIV;
                S_DIV: begin
                    if (i_stat.div_last) r_state <= S_P_UPD;
                end
                S_P_UPD: begin
                    r_phase <= PH_REPL;
                    r_state <= S_SEL_REPL;
                end
                S_SEL_REPL, S_SEL_FOUND, S_SEL_LRU: r_state <= S_RD;
                S_RD:     r_state <= S_UNLINK;
                S_UNLINK: begin
                    if (r_phase == PH_DROP || r_phase == PH_DROPEV) begin
                        r_state <= S_DROP;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    if (r_phase == PH_FOUND) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_gpath) begin
                        r_phase <= PH_FOUND;
                        r_state <= S_SEL_FOUND;
                    end else begin
                        r_state <= S_INSERT;
                    end
                end
                S_DROP: begin
                    if (r_phase == PH_DROPEV) begin
                        r_state <= S_INSERT;
                    end else begin
                        r_phase <= PH_REPL;
                        r_state <= S_SEL_REPL;
                    end
                end
                S_INSERT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/adaptive_replacement_cache_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_replacement_cache_unit
// Adaptive replacement cache policy engine with an APB capacity register.
// ----------------------------------------------------------------------------
// One access key is taken at a time. The directory of 2*MAX_ENTRIES slots is
// searched one slot a cycle through the single read port of its memory, then
// up to two list moves (select, read, unlink, then append or drop) and at most
// one insert follow. A ghost hit also runs the bit-serial divider that sets
// the target step before its list moves. After reset and after every capacity
// write a clearing pass over all 2*MAX_ENTRIES slots empties the directory,
// during which no key is taken. The next key can be taken in the cycle after
// the previous word has been handed to the output register.
module adaptive_replacement_cache_unit #(
    parameter int MAX_ENTRIES = arc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = arc_pkg::KEY_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [arc_pkg::APB_AW-1:0] paddr,
    input  logic [arc_pkg::APB_DW-1:0] pwdata,
    output logic [arc_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [KEY_BITS-1:0]        i_access_key,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_hit,
    output logic [1:0]                 o_ghost_hit,
    output logic                       o_evict_valid,
    output logic [KEY_BITS-1:0]        o_evict_key,
    output logic [arc_pkg::CAP_W-1:0]  o_target_after,
    output logic [arc_pkg::CNT_W-1:0]  o_hit_count,
    output logic [arc_pkg::CNT_W-1:0]  o_miss_count
);
    import arc_pkg::*;

    logic [CAP_W-1:0] r_cache_capacity;
    logic             cfg_wr;
    t_cmd             cmd;
    t_stat            stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_CAP);
    assign prdata = (paddr[2:2] == REG_CAP) ? APB_DW'(r_cache_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cache_capacity <= pwdata[CAP_W-1:0];
        end
    end

    arc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    arc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_wr       (cfg_wr),
        .i_cap          (r_cache_capacity),
        .i_access_key   (i_access_key),
        .i_out_ready    (i_out_ready),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_hit          (o_hit),
        .o_ghost_hit    (o_ghost_hit),
        .o_evict_valid  (o_evict_valid),
        .o_evict_key    (o_evict_key),
        .o_target_after (o_target_after),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count)
    );

endmodule

// ----- hw/rtl/arc_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_chk
// Port-level checks of the adaptive replacement cache unit.
// ----------------------------------------------------------------------------
module arc_chk #(
    parameter int KEY_BITS = arc_pkg::KEY_BITS_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic                      o_hit,
    input logic [1:0]                o_ghost_hit,
    input logic                      o_evict_valid,
    input logic [KEY_BITS-1:0]       o_evict_key,
    input logic [arc_pkg::CNT_W-1:0] o_hit_count
);
    import arc_pkg::*;

    // directory clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("key taken during directory clear");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_evict_key)
            && $stable(o_hit_count))
        else $error("stalled word changed");

    a_evict_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evict_valid |-> o_evict_key == '0)
        else $error("evict key set without eviction");

    a_hit_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_ghost_hit == 2'(GH_NONE) && !o_evict_valid)
        else $error("hit reported with ghost hit or eviction");

    a_ghost_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_ghost_hit != 2'd3)
        else $error("bad ghost hit code");

endmodule

bind adaptive_replacement_cache_unit arc_chk #(.KEY_BITS(KEY_BITS)) u_arc_chk (.*);

// ----- tb/sv/tb_adaptive_replacement_cache_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_replacement_cache_unit
// Self-checking bench for the adaptive replacement cache unit.
// ----------------------------------------------------------------------------
// An ARC policy predictor tracks the four recency lists, the target and the
// counters. Each accepted access key queues one expected word. Each output
// word is checked against the oldest one. Access keys come from small pools
// sized to the capacity, so that hits and ghost hits happen often. A few fully
// random keys are mixed in. The capacity register is rewritten between phases
// only while the unit is idle.

import arc_pkg::*;

typedef struct {
    logic        hit;
    t_ghost      ghost;
    logic        ev;
    logic [31:0] evk;
    logic [6:0]  target;
    logic [31:0] hits;
    logic [31:0] misses;
} t_arc_word;

class arc_scoreboard;
    localparam int SLOTS = 2 * MAX_ENTRIES_DEF;

    logic [31:0] key_of [SLOTS];
    bit          used   [SLOTS];
    t_lst        lst_of [SLOTS];
    int          prv    [SLOTS];
    int          nxt    [SLOTS];
    int          head   [4];
    int          tail   [4];
    int          len    [4];
    int          p;
    logic [31:0] hits_n;
    logic [31:0] misses_n;
    int          cap_reg;
    t_arc_word   pending_q [$];
    int          errors;

    function new();
        errors   = 0;
        hits_n   = '0;
        misses_n = '0;
        cap_reg  = 64;
        clear_dir();
    endfunction

    function void clear_dir();
        for (int i = 0; i < SLOTS; i++) begin
            used[i] = 0;
            lst_of[i] = L_T1;
            prv[i] = 0;
            nxt[i] = 0;
        end
        for (int l = 0; l < 4; l++) begin
            head[l] = 0;
            tail[l] = 0;
            len[l] = 0;
        end
        p = 0;
    endfunction

    function void set_capacity(logic [31:0] value);
        cap_reg = int'(value[6:0]);
        clear_dir();
    endfunction

    function int cap_eff();
        if (cap_reg == 0) return 1;
        if (cap_reg > MAX_ENTRIES_DEF) return MAX_ENTRIES_DEF;
        return cap_reg;
    endfunction

    function void unlink(int s);
        int l;
        l = int'(lst_of[s]);
        if (len[l] == 0) return;
        if (len[l] == 1) begin
            head[l] = 0;
            tail[l] = 0;
        end else if (s == head[l]) begin
            head[l] = nxt[s];
        end else if (s == tail[l]) begin
            tail[l] = prv[s];
        end else begin
            nxt[prv[s]] = nxt[s];
            prv[nxt[s]] = prv[s];
        end
        len[l]--;
    endfunction

    function void append(int s, t_lst l);
        lst_of[s] = l;
        if (len[l] == 0) begin
            head[l] = s;
        end else begin
            nxt[tail[l]] = s;
            prv[s] = tail[l];
        end
        tail[l] = s;
        len[l]++;
    endfunction

    function int pop_lru(t_lst l);
        int s;
        if (len[l] == 0) return -1;
        s = head[l];
        unlink(s);
        return s;
    endfunction

    // move one resident lru key to its ghost list
    function void replace(bit in_b2, ref t_arc_word w);
        int   l1;
        int   s;
        t_lst src;
        l1 = len[L_T1];
        src = (l1 > 0 && (p < l1 || (l1 == p && in_b2))) ? L_T1 : L_T2;
        if (len[src] == 0) src = (src == L_T1) ? L_T2 : L_T1;
        s = pop_lru(src);
        if (s < 0) return;
        append(s, (src == L_T1) ? L_B1 : L_B2);
        w.ev  = 1'b1;
        w.evk = key_of[s];
    endfunction

    function void note_access(logic [31:0] key);
        t_arc_word w;
        int c, found, s, st, lt1, lt2, lb1, lb2, sum;
        c = cap_eff();
        found = -1;
        lt1 = len[L_T1];
        lt2 = len[L_T2];
        lb1 = len[L_B1];
        lb2 = len[L_B2];
        w.hit = 1'b0;
        w.ghost = GH_NONE;
        w.ev = 1'b0;
        w.evk = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (used[i] && key_of[i] == key) begin
                found = i;
                break;
            end
        end
        if (found >= 0 && (lst_of[found] == L_T1 || lst_of[found] == L_T2)) begin
            w.hit = 1'b1;
            hits_n++;
            unlink(found);
            append(found, L_T2);
        end else if (found >= 0) begin
            misses_n++;
            if (lst_of[found] == L_B1) begin
                w.ghost = GH_B1;
                st = (lb1 > 0) ? lb2 / lb1 : 0;
                if (st < 1) st = 1;
                p = (p + st > c) ? c : p + st;
                replace(1'b0, w);
            end else begin
                w.ghost = GH_B2;
                st = (lb2 > 0) ? lb1 / lb2 : 0;
                if (st < 1) st = 1;
                p = (p > st) ? p - st : 0;
                replace(1'b1, w);
            end
            unlink(found);
            append(found, L_T2);
        end else begin
            misses_n++;
            if (lt1 + lb1 == c) begin
                if (lt1 < c) begin
                    s = pop_lru(L_B1);
                    if (s >= 0) used[s] = 0;
                    replace(1'b0, w);
                end else begin
                    s = pop_lru(L_T1);
                    if (s >= 0) begin
                        used[s] = 0;
                        w.ev = 1'b1;
                        w.evk = key_of[s];
                    end
                end
            end else begin
                sum = lt1 + lt2 + lb1 + lb2;
                if (sum >= c) begin
                    if (sum == 2 * c) begin
                        s = pop_lru(L_B2);
                        if (s >= 0) used[s] = 0;
                    end
                    replace(1'b0, w);
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (!used[i]) begin
                    used[i] = 1;
                    key_of[i] = key;
                    append(i, L_T1);
                    break;
                end
            end
        end
        w.target = 7'(p);
        w.hits = hits_n;
        w.misses = misses_n;
        pending_q = {pending_q, w};
    endfunction

    function void check_result(t_arc_word got);
        t_arc_word exp_w;
        if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected output word hit=%0d", got.hit);
            return;
        end
        exp_w = pending_q[0];
        pending_q.delete(0);
        if (got.hit !== exp_w.hit || got.ghost !== exp_w.ghost || got.ev !== exp_w.ev ||
            got.evk !== exp_w.evk || got.target !== exp_w.target ||
            got.hits !== exp_w.hits || got.misses !== exp_w.misses) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch exp: hit=%0d gh=%0d ev=%0d evk=%h p=%0d hc=%0d mc=%0d",
                         exp_w.hit, exp_w.ghost, exp_w.ev, exp_w.evk, exp_w.target,
                         exp_w.hits, exp_w.misses);
                $display("         got: hit=%0d gh=%0d ev=%0d evk=%h p=%0d hc=%0d mc=%0d",
                         got.hit, got.ghost, got.ev, got.evk, got.target,
                         got.hits, got.misses);
            end
        end
    endfunction
endclass

module tb_adaptive_replacement_cache_unit;

    localparam int WATCHDOG_LIMIT = 4000;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [31:0]         i_access_key;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_hit;
    logic [1:0]          o_ghost_hit;
    logic                o_evict_valid;
    logic [31:0]         o_evict_key;
    logic [CAP_W-1:0]    o_target_after;
    logic [CNT_W-1:0]    o_hit_count;
    logic [CNT_W-1:0]    o_miss_count;

    arc_scoreboard sb;
    int            idle_cycles = 0;
    bit            calm_in;
    bit            calm_out;

    adaptive_replacement_cache_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_access_key(i_access_key),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_hit(o_hit), .o_ghost_hit(o_ghost_hit), .o_evict_valid(o_evict_valid),
        .o_evict_key(o_evict_key), .o_target_after(o_target_after),
        .o_hit_count(o_hit_count), .o_miss_count(o_miss_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (sb.pending_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [31:0] value);
        wait_drained();
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = APB_AW'(REG_CAP) << 2;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (pready) sb.set_capacity(value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // caller is at a falling edge; returns at the falling edge after acceptance
    task automatic send_key(logic [31:0] key);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_access_key = key;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_access(key);
        @(negedge i_clk);
    endtask

    task automatic send_phase(int count, logic [31:0] base);
        int c, pool;
        logic [31:0] key;
        c = sb.cap_eff();
        pool = 2 * c + 4;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) calm_in = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 15) == 0) key = $urandom();
            else key = base + $urandom_range(0, pool - 1);
            send_key(key);
        end
        i_in_valid = 1'b0;
    endtask

    // output side
    initial begin
        t_arc_word got;
        int gap;
        i_out_ready = 1'b0;
        calm_out = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 40) == 0) calm_out = ~calm_out;
            gap = calm_out ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.hit = o_hit;
            got.ghost = t_ghost'(o_ghost_hit);
            got.ev = o_evict_valid;
            got.evk = o_evict_key;
            got.target = o_target_after;
            got.hits = o_hit_count;
            got.misses = o_miss_count;
            sb.check_result(got);
        end
    end

    initial begin
        int wait_n;
        sb = new();
        calm_in = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_access_key = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extreme keys, hits, then a small capacity with evictions from t1
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'hAAAA_5555);
        i_in_valid = 1'b0;
        write_capacity(32'd2);
        send_key(32'd1);
        send_key(32'd2);
        send_key(32'd3);     // drops key 1 from t1, no ghost kept
        send_key(32'd1);     // miss, key 1 was dropped
        send_key(32'd2);
        send_key(32'd4);
        send_key(32'd3);
        send_key(32'd1);     // miss, t1 holds 4 and 3
        send_key(32'd5);
        send_key(32'd4);
        i_in_valid = 1'b0;
        // zero acts as one, upper bits of the write ignored
        write_capacity(32'hFFFF_FF80);
        send_key(32'd7);
        send_key(32'd8);
        send_key(32'd7);
        send_key(32'd8);
        i_in_valid = 1'b0;

        write_capacity(32'd1);
        send_phase(120, $urandom());
        write_capacity(32'd127);   // acts as the maximum
        send_phase(200, $urandom());
        write_capacity(32'd4);
        send_phase(100, $urandom());
        wait_drained();            // hold the sender until every word is out
        send_phase(60, 32'h8000_0000);
        write_capacity(32'd16);
        send_phase(150, $urandom());
        write_capacity(32'd64);
        send_phase(150, $urandom());
        write_capacity($urandom_range(1, 63));
        send_phase(120, $urandom());

        wait_n = 0;
        while (sb.pending_q.size() != 0 && wait_n < 20000) begin
            @(negedge i_clk);
            wait_n++;
        end
        repeat (300) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/arc_pkg.sv
hw/rtl/arc_dp.sv
hw/rtl/arc_ctrl.sv
hw/rtl/adaptive_replacement_cache_unit.sv
hw/rtl/arc_chk.sv
tb/sv/tb_adaptive_replacement_cache_unit.sv
